/* src/srr_pkg.sv */
// shared types, widths and constants for the symbol rate register setup block
// no dependencies
package srr_pkg;

  localparam int UNITS_W        = 12;
  localparam int RATE_W         = 26;
  localparam int CODE_W         = 3;
  localparam int INV_W          = 2;
  localparam int BYTE_W         = 8;
  localparam int RATIO_OUT_W    = 24;
  localparam int RATIO_BITS_DEF = 24;

  // dividend is units << 21, fed msb first through the cell row
  localparam int SHIFT_W    = 21;
  localparam int DIVIDEND_W = UNITS_W + SHIFT_W;

  // rate / 100000 == ((rate >> 5) * RECIP_MUL) >> RECIP_FRAC for all 26 bit rates
  localparam int MUL_IN_W    = RATE_W - 5;
  localparam int RECIP_SHIFT = 5;
  localparam int RECIP_FRAC  = 32;
  localparam logic [MUL_IN_W-1:0] RECIP_MUL = 21'd1374390;
  localparam int DIV_W = 10;

  localparam logic [UNITS_W-1:0] UNITS_RESET = 12'd960;

  localparam logic [RATE_W-1:0] RATE_MIN  = 26'd4500000;
  localparam logic [RATE_W-1:0] RATE_B6   = 26'd6000000;
  localparam logic [RATE_W-1:0] RATE_B5   = 26'd9000000;
  localparam logic [RATE_W-1:0] RATE_B4   = 26'd12000000;
  localparam logic [RATE_W-1:0] RATE_B3   = 26'd18000000;
  localparam logic [RATE_W-1:0] RATE_B2   = 26'd24000000;
  localparam logic [RATE_W-1:0] RATE_B1   = 26'd36000000;
  localparam logic [RATE_W-1:0] RATE_MAX  = 26'd45000000;

  localparam logic [BYTE_W-1:0] ROLL_OFF  = 8'h20;
  localparam logic [BYTE_W-1:0] VIT_ON    = 8'h60;
  localparam logic [BYTE_W-1:0] VIT_OFF   = 8'h20;
  localparam logic [BYTE_W-1:0] VIT_AUTO  = 8'h00;

  localparam logic [BYTE_W-1:0] PUNC_HALF  = 8'h80;
  localparam logic [BYTE_W-1:0] PUNC_2_3   = 8'h40;
  localparam logic [BYTE_W-1:0] PUNC_3_4   = 8'h20;
  localparam logic [BYTE_W-1:0] PUNC_5_6   = 8'h08;
  localparam logic [BYTE_W-1:0] PUNC_7_8   = 8'h02;
  localparam logic [BYTE_W-1:0] PUNC_ANY   = 8'hFF;

  localparam logic [CODE_W-1:0] CR_HALF = 3'd1;
  localparam logic [CODE_W-1:0] CR_2_3  = 3'd2;
  localparam logic [CODE_W-1:0] CR_3_4  = 3'd3;
  localparam logic [CODE_W-1:0] CR_5_6  = 3'd4;
  localparam logic [CODE_W-1:0] CR_7_8  = 3'd5;

  localparam logic [INV_W-1:0] INV_OFF = 2'd0;
  localparam logic [INV_W-1:0] INV_ON  = 2'd1;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 56;

  typedef struct packed {
    logic [DIV_W-1:0]   divisor;
    logic [UNITS_W-1:0] units;
    logic [DIV_W-1:0]   rem;
    logic [BYTE_W-1:0]  viterbi;
    logic [BYTE_W-1:0]  filter;
    logic [BYTE_W-1:0]  puncture;
    logic               unsup;
    logic               div_zero;
  } srr_item_t;

  function automatic logic [2:0] band_code(input logic [RATE_W-1:0] rate);
    logic [2:0] code;
    if (rate < RATE_MIN)      code = 3'd0;
    else if (rate <= RATE_B6) code = 3'd7;
    else if (rate <= RATE_B5) code = 3'd6;
    else if (rate <= RATE_B4) code = 3'd5;
    else if (rate <= RATE_B3) code = 3'd4;
    else if (rate <= RATE_B2) code = 3'd3;
    else if (rate <= RATE_B1) code = 3'd2;
    else if (rate <= RATE_MAX) code = 3'd1;
    else                      code = 3'd0;
    return code;
  endfunction

  function automatic logic [BYTE_W-1:0] puncture_for(input logic [CODE_W-1:0] code);
    logic [BYTE_W-1:0] mask;
    unique case (code)
      CR_HALF: mask = PUNC_HALF;
      CR_2_3:  mask = PUNC_2_3;
      CR_3_4:  mask = PUNC_3_4;
      CR_5_6:  mask = PUNC_5_6;
      CR_7_8:  mask = PUNC_7_8;
      default: mask = PUNC_ANY;
    endcase
    return mask;
  endfunction

  function automatic logic [BYTE_W-1:0] viterbi_for(input logic [INV_W-1:0] inv);
    logic [BYTE_W-1:0] v;
    unique case (inv)
      INV_OFF: v = VIT_OFF;
      INV_ON:  v = VIT_ON;
      default: v = VIT_AUTO;
    endcase
    return v;
  endfunction

endpackage

/* src/symbol_rate_register_setup.sv */
// top level: symbol rate register setup, front end plus a row of divider cells
// depends on srr_pkg, srr_front, srr_div_cell
// pipeline: 2 front stages, then 33 divider cells, every stage registered
// throughput: one request per cycle; the row of divider cells, one quotient bit per cell
// each stage holds its item while the next one stalls; empty stages fill behind a stall
// reset: synchronous active low, clears all stage valids, clock register back to 960
module symbol_rate_register_setup #(
  parameter int RATIO_BITS = srr_pkg::RATIO_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srr_pkg::UNITS_W-1:0]     cfg_data,     // system_clock_units
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // symbol_rate[25:0], code_rate[28:26], inversion_mode[30:29], zero pad
  input  logic [srr_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // viterbi_setting[7:0], clock_ratio[31:8], filter_setting[39:32],
  // puncture_mask[47:40], rate_unsupported[48], zero pad
  output logic [srr_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import srr_pkg::*;

  localparam int NCELL = DIVIDEND_W;
  localparam int EXT_W = (RATIO_BITS > RATIO_OUT_W) ? RATIO_BITS : RATIO_OUT_W;

  logic [UNITS_W-1:0] units_r;

  logic      f_valid;
  logic      f_ready;
  srr_item_t f_item;

  logic                  c_valid [NCELL+1];
  logic                  c_ready [NCELL+1];
  srr_item_t             c_item  [NCELL+1];
  logic [RATIO_BITS-1:0] c_quot  [NCELL+1];

  srr_item_t             last_item;
  logic [RATIO_BITS-1:0] ratio;
  logic [EXT_W-1:0]      ratio_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      units_r <= UNITS_RESET;
    end else if (cfg_valid) begin
      units_r <= cfg_data;
    end
  end

  srr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .rate      (in_tdata[RATE_W-1:0]),
    .code      (in_tdata[RATE_W +: CODE_W]),
    .inv       (in_tdata[RATE_W+CODE_W +: INV_W]),
    .units     (units_r),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  assign c_valid[0] = f_valid;
  assign f_ready    = c_ready[0];
  assign c_item[0]  = f_item;
  assign c_quot[0]  = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    srr_div_cell #(
      .IDX        (i),
      .RATIO_BITS (RATIO_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (c_valid[i]),
      .in_ready  (c_ready[i]),
      .in_item   (c_item[i]),
      .in_quot   (c_quot[i]),
      .out_valid (c_valid[i+1]),
      .out_ready (c_ready[i+1]),
      .out_item  (c_item[i+1]),
      .out_quot  (c_quot[i+1])
    );
  end

  assign c_ready[NCELL] = out_tready;
  assign last_item      = c_item[NCELL];

  // zero divisor saturates
  assign ratio     = last_item.div_zero ? {RATIO_BITS{1'b1}} : c_quot[NCELL];
  assign ratio_ext = EXT_W'(ratio);

  assign out_tvalid = c_valid[NCELL];
  assign out_tdata  = {7'b0, last_item.unsup, last_item.puncture, last_item.filter,
                       ratio_ext[RATIO_OUT_W-1:0], last_item.viterbi};

  a_band_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[34:32] == 3'd0) == out_tdata[48]))
    else $error("band code and unsupported flag disagree");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output stage empty");

  a_viterbi: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] == VIT_ON || out_tdata[7:0] == VIT_OFF ||
                    out_tdata[7:0] == VIT_AUTO))
    else $error("bad viterbi byte");

  a_puncture: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($onehot(out_tdata[47:40]) || out_tdata[47:40] == PUNC_ANY))
    else $error("bad puncture mask");

  a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && last_item.div_zero) |-> (out_tdata[48] && out_tdata[34:32] == 3'd0))
    else $error("zero divisor not flagged");

endmodule

/* src/srr_front.sv */
// front end: decodes the request bytes and turns the symbol rate into the divisor
// depends on srr_pkg; two registered stages with a ready chain
module srr_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [srr_pkg::RATE_W-1:0]  rate,
  input  logic [srr_pkg::CODE_W-1:0]  code,
  input  logic [srr_pkg::INV_W-1:0]   inv,
  input  logic [srr_pkg::UNITS_W-1:0] units,
  output logic                       out_valid,
  input  logic                       out_ready,
  output srr_pkg::srr_item_t         out_item
);
  import srr_pkg::*;

  logic                a_v_r, a_v_nxt;
  logic [RATE_W-1:0]   a_rate_r;
  srr_item_t           a_item_r;
  logic                a_ready;

  logic                b_v_r, b_v_nxt;
  srr_item_t           b_item_r, b_item_nxt;
  logic                b_ready;

  logic [2*MUL_IN_W-1:0] prod;
  logic [DIV_W-1:0]      divisor;

  assign b_ready  = !b_v_r || out_ready;
  assign a_ready  = !a_v_r || b_ready;
  assign in_ready = a_ready;

  // reciprocal multiply for the divide by 100000
  assign prod    = (2*MUL_IN_W)'(a_rate_r[RATE_W-1:RECIP_SHIFT]) * (2*MUL_IN_W)'(RECIP_MUL);
  assign divisor = prod[RECIP_FRAC +: DIV_W];

  always_comb begin
    a_v_nxt = a_v_r;
    if (a_ready) a_v_nxt = in_valid;
    b_v_nxt = b_v_r;
    if (b_ready) b_v_nxt = a_v_r;
    b_item_nxt          = a_item_r;
    b_item_nxt.divisor  = divisor;
    b_item_nxt.div_zero = (divisor == '0);
    b_item_nxt.unsup    = a_item_r.unsup || (divisor == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_rate_r          <= rate;
      a_item_r.divisor  <= '0;
      a_item_r.units    <= units;
      a_item_r.rem      <= '0;
      a_item_r.viterbi  <= viterbi_for(inv);
      a_item_r.filter   <= ROLL_OFF | BYTE_W'(band_code(rate));
      a_item_r.puncture <= puncture_for(code);
      a_item_r.unsup    <= (rate < RATE_MIN) || (rate > RATE_MAX);
      a_item_r.div_zero <= 1'b0;
    end
    if (b_ready && a_v_r) begin
      b_item_r <= b_item_nxt;
    end
  end

  assign out_valid = b_v_r;
  assign out_item  = b_item_r;

endmodule

/* src/srr_div_cell.sv */
// one restoring divider cell: brings down one dividend bit, produces one quotient bit
// depends on srr_pkg; position in the row set by IDX
module srr_div_cell #(
  parameter int IDX        = 0,
  parameter int RATIO_BITS = srr_pkg::RATIO_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  srr_pkg::srr_item_t    in_item,
  input  logic [RATIO_BITS-1:0] in_quot,
  output logic                  out_valid,
  input  logic                  out_ready,
  output srr_pkg::srr_item_t    out_item,
  output logic [RATIO_BITS-1:0] out_quot
);
  import srr_pkg::*;

  localparam int BIT_POS = DIVIDEND_W - 1 - IDX;

  logic                  v_r, v_nxt;
  srr_item_t             item_r, item_nxt;
  logic [RATIO_BITS-1:0] quot_r;

  logic [DIVIDEND_W-1:0] dividend;
  logic [DIV_W:0]        shifted;
  logic [DIV_W:0]        diff;
  logic                  qbit;
  logic [DIV_W-1:0]      rem_nxt;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    dividend     = {in_item.units, {SHIFT_W{1'b0}}};
    shifted      = {in_item.rem, dividend[BIT_POS]};
    diff         = shifted - {1'b0, in_item.divisor};
    qbit         = (shifted >= {1'b0, in_item.divisor});
    rem_nxt      = qbit ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    v_nxt        = in_ready ? in_valid : v_r;
    item_nxt     = in_item;
    item_nxt.rem = rem_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
      // upper quotient bits fall off: ratio kept modulo 2^RATIO_BITS
      quot_r <= {in_quot[RATIO_BITS-2:0], qbit};
    end
  end

  assign out_valid = v_r;
  assign out_item  = item_r;
  assign out_quot  = quot_r;

endmodule
